@@ hw/rtl/p25vrf_pkg.sv @@
// ---------------------------------------------------------------------------
// p25vrf_pkg
// shared types, constants and template tables for the voice record framer
// ---------------------------------------------------------------------------
package p25vrf_pkg;

    localparam int unsigned NumRec     = 18;
    localparam int unsigned RecIdxW    = 5;
    localparam int unsigned CfgIdxW    = 1;
    localparam int unsigned IdW        = 24;
    localparam int unsigned VoiceBytes = 11;
    localparam int unsigned VoiceW     = 8 * VoiceBytes;
    localparam int unsigned PosW       = 5;
    localparam int unsigned KindW      = 3;
    localparam int unsigned QDepth     = 2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_SOURCE_ID  = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_DEST_GROUP = 1'd1;

    // input opcodes
    localparam logic OP_VOICE = 1'b0;
    localparam logic OP_END   = 1'b1;

    // record layout classes
    localparam logic [KindW-1:0] KIND_LONG  = 3'd0;
    localparam logic [KindW-1:0] KIND_SHORT = 3'd1;
    localparam logic [KindW-1:0] KIND_MID   = 3'd2;
    localparam logic [KindW-1:0] KIND_STD   = 3'd3;
    localparam logic [KindW-1:0] KIND_TERM  = 3'd4;

    // template indexes with a special layout
    localparam logic [RecIdxW-1:0] REC_LONG_A  = 5'd0;
    localparam logic [RecIdxW-1:0] REC_SHORT_A = 5'd1;
    localparam logic [RecIdxW-1:0] REC_DEST    = 5'd3;
    localparam logic [RecIdxW-1:0] REC_SRC     = 5'd4;
    localparam logic [RecIdxW-1:0] REC_MID_A   = 5'd8;
    localparam logic [RecIdxW-1:0] REC_LONG_B  = 5'd9;
    localparam logic [RecIdxW-1:0] REC_SHORT_B = 5'd10;
    localparam logic [RecIdxW-1:0] REC_LAST    = 5'(NumRec - 1);

    localparam logic [7:0] TYPE_BASE = 8'h62;
    localparam logic [7:0] TYPE_TERM = 8'h80;
    localparam logic [7:0] FILL_02   = 8'h02;

    localparam logic [PosW-1:0] LEN_LONG  = 5'd22;
    localparam logic [PosW-1:0] LEN_SHORT = 5'd14;
    localparam logic [PosW-1:0] LEN_MID   = 5'd16;
    localparam logic [PosW-1:0] LEN_STD   = 5'd17;
    localparam logic [PosW-1:0] LEN_TERM  = 5'd17;

    localparam logic [PosW-1:0] OFF_LONG  = 5'd10;
    localparam logic [PosW-1:0] OFF_SHORT = 5'd1;
    localparam logic [PosW-1:0] OFF_MID   = 5'd4;
    localparam logic [PosW-1:0] OFF_STD   = 5'd5;

    localparam logic [PosW-1:0] POS_SHORT_FILL = 5'd13;
    localparam logic [PosW-1:0] POS_MID_FILL   = 5'd3;
    localparam logic [PosW-1:0] POS_STD_FILL   = 5'd16;
    localparam logic [PosW-1:0] POS_HDR_END    = 5'd3;

    typedef struct packed {
        logic        opcode;
        logic [23:0] voice_head;
        logic [63:0] voice_tail;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       record_last;
    } out_word_t;

    typedef struct packed {
        logic [KindW-1:0]  kind;
        logic [7:0]        type_byte;
        logic [IdW-1:0]    hdr;
        logic [VoiceW-1:0] voice;
    } rec_desc_t;

    typedef struct packed {
        logic      push;
        rec_desc_t desc;
    } q_push_t;

    function automatic logic [IdW-1:0] fixed_hdr(input logic [RecIdxW-1:0] idx);
        logic [IdW-1:0] h;
        unique case (idx)
            5'd5:    h = 24'hF09D6A;
            5'd6:    h = 24'h19D426;
            5'd7:    h = 24'hE0EB7B;
            5'd15:   h = 24'hACB8A4;
            5'd16:   h = 24'h9BDC75;
            default: h = 24'h000000;
        endcase
        return h;
    endfunction

    // bytes 1..9 of the long records
    function automatic logic [7:0] long_prefix(input logic [3:0] pos);
        logic [7:0] b;
        unique case (pos)
            4'd1:    b = 8'h02;
            4'd2:    b = 8'h02;
            4'd3:    b = 8'h0C;
            4'd4:    b = 8'h0B;
            4'd5:    b = 8'h12;
            4'd6:    b = 8'h64;
            4'd9:    b = 8'h80;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/p25vrf_front.sv @@
// ---------------------------------------------------------------------------
// p25vrf_front
// accepts words, holds the id registers and the template sequence, and
// turns each word into a record descriptor for the queue
// ---------------------------------------------------------------------------
module p25vrf_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [p25vrf_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [p25vrf_pkg::IdW-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  p25vrf_pkg::in_word_t             in_data,
    input  logic                             q_full,
    output p25vrf_pkg::q_push_t              q_push
);

    logic [p25vrf_pkg::IdW-1:0]     source_id_reg;
    logic [p25vrf_pkg::IdW-1:0]     dest_group_reg;
    logic [p25vrf_pkg::RecIdxW-1:0] rec_idx_reg;
    logic [p25vrf_pkg::RecIdxW-1:0] rec_idx_next;
    logic [p25vrf_pkg::RecIdxW-1:0] idx_eff;
    logic                           accept;
    p25vrf_pkg::rec_desc_t          desc;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_id_reg  <= '0;
            dest_group_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                p25vrf_pkg::CFG_SOURCE_ID:  source_id_reg  <= cfg_data;
                p25vrf_pkg::CFG_DEST_GROUP: dest_group_reg <= cfg_data;
                default:                    source_id_reg  <= source_id_reg;
            endcase
        end
    end

    // out of range indexes behave as the last template
    assign idx_eff = (rec_idx_reg >= p25vrf_pkg::RecIdxW'(p25vrf_pkg::NumRec))
                     ? p25vrf_pkg::REC_LAST : rec_idx_reg;

    always_comb
    begin
        desc.voice     = {in_data.voice_head, in_data.voice_tail};
        desc.type_byte = p25vrf_pkg::TYPE_BASE + {3'b000, idx_eff};
        desc.hdr       = p25vrf_pkg::fixed_hdr(idx_eff);
        desc.kind      = p25vrf_pkg::KIND_STD;
        rec_idx_next   = (idx_eff == p25vrf_pkg::REC_LAST) ? '0 : idx_eff + 5'd1;
        priority if (in_data.opcode == p25vrf_pkg::OP_END)
        begin
            desc.kind      = p25vrf_pkg::KIND_TERM;
            desc.type_byte = p25vrf_pkg::TYPE_TERM;
            desc.hdr       = '0;
            rec_idx_next   = '0;
        end
        else if (idx_eff == p25vrf_pkg::REC_LONG_A || idx_eff == p25vrf_pkg::REC_LONG_B)
        begin
            desc.kind = p25vrf_pkg::KIND_LONG;
        end
        else if (idx_eff == p25vrf_pkg::REC_SHORT_A || idx_eff == p25vrf_pkg::REC_SHORT_B)
        begin
            desc.kind = p25vrf_pkg::KIND_SHORT;
        end
        else if (idx_eff == p25vrf_pkg::REC_MID_A || idx_eff == p25vrf_pkg::REC_LAST)
        begin
            desc.kind = p25vrf_pkg::KIND_MID;
        end
        else if (idx_eff == p25vrf_pkg::REC_DEST)
        begin
            desc.hdr = dest_group_reg;
        end
        else if (idx_eff == p25vrf_pkg::REC_SRC)
        begin
            desc.hdr = source_id_reg;
        end
        else
        begin
            desc.kind = p25vrf_pkg::KIND_STD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_idx_reg <= '0;
        end
        else if (accept)
        begin
            rec_idx_reg <= rec_idx_next;
        end
    end

    assign q_push.push = accept;
    assign q_push.desc = desc;

endmodule

@@ hw/rtl/p25vrf_queue.sv @@
// ---------------------------------------------------------------------------
// p25vrf_queue
// small descriptor queue between the front and the byte emitter
// ---------------------------------------------------------------------------
module p25vrf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  p25vrf_pkg::q_push_t   q_push,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output p25vrf_pkg::rec_desc_t head
);

    localparam int unsigned PtrW = $clog2(p25vrf_pkg::QDepth);
    localparam int unsigned CntW = $clog2(p25vrf_pkg::QDepth + 1);

    p25vrf_pkg::rec_desc_t entry_reg [p25vrf_pkg::QDepth];
    logic [PtrW-1:0]       wr_ptr_reg;
    logic [PtrW-1:0]       rd_ptr_reg;
    logic [CntW-1:0]       count_reg;
    logic [CntW-1:0]       count_next;

    assign full  = (count_reg == CntW'(p25vrf_pkg::QDepth));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (q_push.push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !q_push.push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            entry_reg[wr_ptr_reg] <= q_push.desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (q_push.push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(p25vrf_pkg::QDepth - 1))
                              ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(p25vrf_pkg::QDepth - 1))
                              ? '0 : rd_ptr_reg + PtrW'(1);
            end
        end
    end

endmodule

@@ hw/rtl/p25vrf_back.sv @@
// ---------------------------------------------------------------------------
// p25vrf_back
// walks the head descriptor one byte per cycle, unless stalled, into out_data
// ---------------------------------------------------------------------------
module p25vrf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  p25vrf_pkg::rec_desc_t head,
    input  logic                  q_empty,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output p25vrf_pkg::out_word_t out_data
);

    logic [p25vrf_pkg::PosW-1:0] pos_reg;
    logic [p25vrf_pkg::PosW-1:0] rec_len;
    logic [p25vrf_pkg::PosW-1:0] voice_off;
    logic [p25vrf_pkg::PosW-1:0] voice_pos;
    logic [p25vrf_pkg::VoiceW-1:0] voice_shift;
    logic [7:0]                  voice_byte;
    logic [7:0]                  cur_byte;
    logic                        in_voice;
    logic                        is_last;
    logic                        advance;
    logic                        fire;
    logic                        out_valid_reg;
    p25vrf_pkg::out_word_t       out_word_reg;

    assign advance = !out_valid_reg || out_ready;
    assign fire    = advance && !q_empty;

    always_comb
    begin
        unique case (head.kind)
            p25vrf_pkg::KIND_LONG:
            begin
                rec_len   = p25vrf_pkg::LEN_LONG;
                voice_off = p25vrf_pkg::OFF_LONG;
            end
            p25vrf_pkg::KIND_SHORT:
            begin
                rec_len   = p25vrf_pkg::LEN_SHORT;
                voice_off = p25vrf_pkg::OFF_SHORT;
            end
            p25vrf_pkg::KIND_MID:
            begin
                rec_len   = p25vrf_pkg::LEN_MID;
                voice_off = p25vrf_pkg::OFF_MID;
            end
            p25vrf_pkg::KIND_STD:
            begin
                rec_len   = p25vrf_pkg::LEN_STD;
                voice_off = p25vrf_pkg::OFF_STD;
            end
            default:
            begin
                rec_len   = p25vrf_pkg::LEN_TERM;
                voice_off = p25vrf_pkg::OFF_STD;
            end
        endcase
    end

    assign is_last     = (pos_reg == rec_len - 5'd1);
    assign voice_pos   = pos_reg - voice_off;
    assign in_voice    = (head.kind != p25vrf_pkg::KIND_TERM) && (pos_reg >= voice_off)
                         && (voice_pos < p25vrf_pkg::PosW'(p25vrf_pkg::VoiceBytes));
    assign voice_shift = head.voice << {voice_pos, 3'b000};
    assign voice_byte  = voice_shift[p25vrf_pkg::VoiceW-1 -: 8];

    always_comb
    begin
        cur_byte = 8'h00;
        priority if (pos_reg == '0)
        begin
            cur_byte = head.type_byte;
        end
        else if (in_voice)
        begin
            cur_byte = voice_byte;
        end
        else if (head.kind == p25vrf_pkg::KIND_LONG && pos_reg < p25vrf_pkg::OFF_LONG)
        begin
            cur_byte = p25vrf_pkg::long_prefix(pos_reg[3:0]);
        end
        else if (head.kind == p25vrf_pkg::KIND_SHORT && pos_reg == p25vrf_pkg::POS_SHORT_FILL)
        begin
            cur_byte = p25vrf_pkg::FILL_02;
        end
        else if (head.kind == p25vrf_pkg::KIND_MID && pos_reg == p25vrf_pkg::POS_MID_FILL)
        begin
            cur_byte = p25vrf_pkg::FILL_02;
        end
        else if (head.kind == p25vrf_pkg::KIND_STD && pos_reg <= p25vrf_pkg::POS_HDR_END)
        begin
            cur_byte = head.hdr[8 * (3 - pos_reg[1:0]) +: 8];
        end
        else if (head.kind == p25vrf_pkg::KIND_STD && pos_reg == p25vrf_pkg::POS_STD_FILL)
        begin
            cur_byte = p25vrf_pkg::FILL_02;
        end
        else
        begin
            cur_byte = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire;
            if (fire)
            begin
                pos_reg <= is_last ? '0 : pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_word_reg.out_byte    <= cur_byte;
            out_word_reg.record_last <= is_last;
        end
    end

    assign pop       = fire && is_last;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

@@ hw/rtl/p25_voice_record_framer_unit.sv @@
// ---------------------------------------------------------------------------
// p25_voice_record_framer_unit
// wraps imbe voice frames into ldu network records, one byte per word
// ---------------------------------------------------------------------------
// Each voice word becomes the next of 18 record templates (types 0x62 to
// 0x73, then back to 0x62) and an end word becomes the 17-byte 0x80
// terminator, which also restarts the sequence. Records leave one byte per
// cycle while out_ready is high; the byte emitter is the only throughput
// limit. A two-entry descriptor queue lets new words be taken while a record
// is still going out. The user must write the ids on the cfg port (index 0
// source id, index 1 talk group) only while the unit is idle; the unit does
// not enforce this itself. cfg_ready is always high.
module p25_voice_record_framer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [p25vrf_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [p25vrf_pkg::IdW-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  p25vrf_pkg::in_word_t           in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output p25vrf_pkg::out_word_t          out_data
);

    p25vrf_pkg::q_push_t   q_push;
    p25vrf_pkg::rec_desc_t q_head;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;

    p25vrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_full    (q_full),
        .q_push    (q_push)
    );

    p25vrf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (q_pop),
        .full   (q_full),
        .empty  (q_empty),
        .head   (q_head)
    );

    p25vrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ hw/rtl/p25vrf_checker.sv @@
// ---------------------------------------------------------------------------
// p25vrf_checker
// port-level checks on record framing and output handshake
// ---------------------------------------------------------------------------
module p25vrf_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input p25vrf_pkg::out_word_t out_data
);

    logic [p25vrf_pkg::PosW-1:0] cnt_reg;
    logic                        out_fire;

    assign out_fire = out_valid && out_ready;

    // byte position within the current record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (out_fire)
        begin
            cnt_reg <= out_data.record_last ? '0 : cnt_reg + 5'd1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && cnt_reg == '0 |->
            (out_data.out_byte >= 8'h62 && out_data.out_byte <= 8'h73)
            || out_data.out_byte == 8'h80)
        else $error("record opens with an unknown type byte");

    a_last_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_data.record_last |->
            cnt_reg == 5'd13 || cnt_reg == 5'd15 || cnt_reg == 5'd16 || cnt_reg == 5'd21)
        else $error("record ended at an illegal length");

    a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !out_data.record_last |-> cnt_reg < 5'd21)
        else $error("record ran past the longest template");

endmodule

bind p25_voice_record_framer_unit p25vrf_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
